[rtl/bsp_pkg.sv]
`timescale 1ns / 1ps

package bsp_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATED_MASK = 2'd2;

  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_HELD    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic fire;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

[rtl/bsp_in_if.sv]
`timescale 1ns / 1ps

interface bsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] button;

  modport source (output valid, output action, output button, input ready);
  modport sink (input valid, input action, input button, output ready);
endinterface

[rtl/bsp_out_if.sv]
`timescale 1ns / 1ps

interface bsp_out_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic       continuous_start;
  logic       continuous_stop;
  logic [3:0] position_after;
  logic       sequence_reset;

  modport source (output valid, output fired, output continuous_start,
                  output continuous_stop, output position_after,
                  output sequence_reset, input ready);
  modport sink (input valid, input fired, input continuous_start,
                input continuous_stop, input position_after,
                input sequence_reset, output ready);
endinterface

[rtl/bsp_ctrl.sv]
`timescale 1ns / 1ps

module bsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bsp_pkg::ctl_sts_t sts,
  output bsp_pkg::ctl_cmd_t cmd
);
  import bsp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.fire ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r != ST_IDLE)
    else $error("accepted word did not leave idle");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !sts.scan_last) |=> state_r == ST_SCAN)
    else $error("button scan cut short");

  a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == ST_IDLE)
    else $error("emit did not return to idle");
`endif

endmodule

[rtl/bsp_datapath.sv]
`timescale 1ns / 1ps

module bsp_datapath #(
  parameter int MAX_STEPS   = 8,
  parameter int NUM_BUTTONS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsp_pkg::ctl_cmd_t                   cmd,
  output bsp_pkg::ctl_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                          in_action,
  input  logic [5:0]                          in_button,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_fired,
  output logic                                out_continuous_start,
  output logic                                out_continuous_stop,
  output logic [bsp_pkg::POS_W-1:0]           out_position_after,
  output logic                                out_sequence_reset
);
  import bsp_pkg::*;

  localparam int BW = $clog2(NUM_BUTTONS);
  localparam int SW = MAX_STEPS * 8;
  localparam logic [POS_W-1:0] MAXS = POS_W'(MAX_STEPS);
  localparam logic [6:0] NB7 = 7'(NUM_BUTTONS);

  logic [SW-1:0]          step_tab_r;
  logic [3:0]             step_cnt_r;
  logic [NUM_BUTTONS-1:0] neg_r;
  logic [NUM_BUTTONS-1:0] pressed_r;
  logic [POS_W-1:0]       pos_r;
  logic [POS_W-1:0]       pos_nxt;
  logic                   cont_r;
  logic [BW-1:0]          scan_r;
  logic                   fired_p_r;
  logic                   cstart_p_r;
  logic                   cstop_p_r;
  logic                   sreset_p_r;
  logic                   out_valid_r;
  logic                   o_fired_r;
  logic                   o_cstart_r;
  logic                   o_cstop_r;
  logic [POS_W-1:0]       o_pos_r;
  logic                   o_sreset_r;

  logic [7:0]             step_b [8];
  logic [7:0]             is_held;
  logic [7:0]             held_pressed;
  logic [POS_W-1:0]       n_used;
  logic [7:0]             cur;
  logic                   pos_live;
  logic [POS_W-1:0]       pos_inc;
  logic                   in_range;
  logic                   is_tick;
  logic [NUM_BUTTONS-1:0] pressed_ev;
  logic                   neg_ok;
  logic                   ev_match;
  logic                   ev_fire;
  logic                   ev_sreset;
  logic [POS_W-1:0]       ev_pos;
  logic                   cont_pat;
  logic                   should;
  logic                   tk_start;
  logic                   tk_stop;
  logic                   scan_hit;

  for (genvar k = 0; k < 8; k++) begin : g_step
    if (k < MAX_STEPS) begin : g_used
      assign step_b[k] = step_tab_r[k*8 +: 8];
    end else begin : g_pad
      assign step_b[k] = 8'h00;
    end
    assign is_held[k] = step_b[k][7:6] == ACT_HELD;
    assign held_pressed[k] = ({1'b0, step_b[k][5:0]} < NB7) &&
                             pressed_r[step_b[k][BW-1:0]];
  end

  assign n_used   = (step_cnt_r > MAXS) ? MAXS : step_cnt_r;
  assign cur      = step_b[pos_r[2:0]];
  assign pos_live = pos_r < n_used;
  assign pos_inc  = pos_r + POS_W'(1);
  assign in_range = {1'b0, in_button} < NB7;
  assign is_tick  = in_action == ACT_TICK;

  always_comb begin
    pressed_ev = pressed_r;
    if (in_action == ACT_PRESS) begin
      pressed_ev[in_button[BW-1:0]] = 1'b1;
    end else if (in_action == ACT_RELEASE) begin
      pressed_ev[in_button[BW-1:0]] = 1'b0;
    end
  end

  assign neg_ok   = (neg_r & pressed_ev) == '0;
  assign ev_match = pos_live && (cur[7:6] == in_action) && (cur[5:0] == in_button);

  always_comb begin
    ev_pos    = pos_r;
    ev_fire   = 1'b0;
    ev_sreset = 1'b0;
    if (ev_match) begin
      if (!neg_ok) begin
        ev_pos    = '0;
        ev_sreset = pos_r != '0;
      end else if (pos_inc == n_used) begin
        ev_pos  = '0;
        ev_fire = 1'b1;
      end else begin
        ev_pos = pos_inc;
      end
    end else if (in_action == ACT_RELEASE && pos_r != '0) begin
      ev_pos    = '0;
      ev_sreset = 1'b1;
    end
  end

  always_comb begin
    cont_pat = n_used != '0;
    should   = (neg_r & pressed_r) == '0;
    for (int k = 0; k < 8; k++) begin
      if (POS_W'(k) < n_used) begin
        if (!is_held[k]) begin
          cont_pat = 1'b0;
        end else if (!held_pressed[k]) begin
          should = 1'b0;
        end
      end
    end
  end

  assign tk_start = cont_pat && should && !cont_r;
  assign tk_stop  = cont_pat && !should && cont_r;

  assign scan_hit = pos_live && (cur[7:6] == ACT_HELD) &&
                    (cur[5:0] == 6'(scan_r)) && pressed_r[scan_r];

  assign sts.fire      = ev_fire && !is_tick && in_range;
  assign sts.scan_last = scan_r == BW'(NUM_BUTTONS - 1);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.accept && !is_tick && in_range) begin
      pos_nxt = ev_pos;
    end else if (cmd.scan && scan_hit) begin
      pos_nxt = pos_inc;
    end
    if (cfg_we && (cfg_index == CFG_STEP_TABLE || cfg_index == CFG_STEP_COUNT)) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_tab_r  <= '0;
      step_cnt_r  <= '0;
      neg_r       <= '0;
      pressed_r   <= '0;
      pos_r       <= '0;
      cont_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (cmd.accept) begin
        if (is_tick) begin
          if (tk_start) begin
            cont_r <= 1'b1;
          end else if (tk_stop) begin
            cont_r <= 1'b0;
          end
        end else if (in_range) begin
          pressed_r <= pressed_ev;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_TABLE:   step_tab_r <= cfg_data[SW-1:0];
          CFG_STEP_COUNT:   step_cnt_r <= cfg_data[3:0];
          CFG_NEGATED_MASK: neg_r      <= cfg_data[NUM_BUTTONS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_r     <= '0;
      fired_p_r  <= sts.fire;
      sreset_p_r <= ev_sreset && !is_tick && in_range;
      cstart_p_r <= tk_start && is_tick;
      cstop_p_r  <= tk_stop && is_tick;
    end else if (cmd.scan) begin
      scan_r <= scan_r + BW'(1);
    end
    if (cmd.emit) begin
      o_fired_r  <= fired_p_r;
      o_cstart_r <= cstart_p_r;
      o_cstop_r  <= cstop_p_r;
      o_pos_r    <= pos_r;
      o_sreset_r <= sreset_p_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_fired            = o_fired_r;
  assign out_continuous_start = o_cstart_r;
  assign out_continuous_stop  = o_cstop_r;
  assign out_position_after   = o_pos_r;
  assign out_sequence_reset   = o_sreset_r;

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAXS)
    else $error("sequence position beyond last step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(fired_p_r && sreset_p_r) && !(cstart_p_r && cstop_p_r))
    else $error("conflicting result flags");
`endif

endmodule

[rtl/button_sequence_pattern_detector_top.sv]
`timescale 1ns / 1ps

// Button sequence detector.
// in_ch carries one word per button event (action, button) or update tick;
// each accepted word yields exactly one result word on out_ch with fired,
// continuous_start, continuous_stop, position_after and sequence_reset.
// cfg_we/cfg_index/cfg_data write step_table (0), step_count (1) and
// negated_mask (2); write only while no word is in flight.
// For most words the controller goes from idle straight to the emit state,
// which loads the output register. A word that completes the sequence first
// runs a re-advance scan over all buttons, one button id per cycle.
// The controller handles one word at a time and takes the next word only
// once it is back in idle.
// The result sits in an output register; the next word is accepted while it
// waits. A stalled receiver holds the result and blocks the following one.
// Reset (rst_n low, synchronous) clears the configuration, the pressed
// bitmap, the position and the continuous flag, and drops any pending word.

module button_sequence_pattern_detector_top #(
  parameter int MAX_STEPS   = 8,
  parameter int NUM_BUTTONS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bsp_in_if.sink                         in_ch,
  bsp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsp_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsp_datapath #(
    .MAX_STEPS   (MAX_STEPS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_action            (in_ch.action),
    .in_button            (in_ch.button),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_fired            (out_ch.fired),
    .out_continuous_start (out_ch.continuous_start),
    .out_continuous_stop  (out_ch.continuous_stop),
    .out_position_after   (out_ch.position_after),
    .out_sequence_reset   (out_ch.sequence_reset)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bsp_pkg::*;

  localparam logic [1:0] KIND_VOID = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_WORDS = 117;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic       fired;
    logic       cont_start;
    logic       cont_stop;
    logic [3:0] position;
    logic       seq_reset;
  } det_result_t;

  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [63:0] reg_val;
    logic [1:0]  act;
    logic [5:0]  btn;
    bit          known;
    det_result_t want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bsp_in_if in_ch ();
  bsp_out_if out_ch ();

  button_sequence_pattern_detector_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [63:0] m_table;
  logic [63:0] m_neg;
  logic [63:0] m_pressed;
  logic [3:0]  m_count;
  logic [3:0]  m_pos;
  bit          m_cont;

  det_result_t pending_results[$];
  script_row_t script[$];
  logic [5:0]  pool[6];
  int errors;
  int gap_pct;
  int stall_pct;
  int hold_left;
  int stall_left;
  int idle_cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned live_steps();
    return (m_count > 4'd8) ? 8 : int'(m_count);
  endfunction

  function automatic logic [7:0] step_at(int unsigned k);
    return m_table[k*8 +: 8];
  endfunction

  function automatic bit step_hit(int unsigned pos, logic [1:0] kind, logic [5:0] id);
    logic [7:0] b;
    if (pos >= live_steps()) return 1'b0;
    b = step_at(pos);
    return (b[7:6] == kind) && (b[5:0] == id);
  endfunction

  function automatic det_result_t detector_next(logic [1:0] act, logic [5:0] id);
    det_result_t r;
    int unsigned n;
    int k;
    logic [7:0] b;
    bit cont;
    bit want;
    r = '0;
    if (act == ACT_TICK) begin
      n = live_steps();
      cont = (n > 0);
      want = 1'b1;
      for (k = 0; k < int'(n); k++) begin
        b = step_at(k);
        if (b[7:6] != ACT_HELD) cont = 1'b0;
        else if (!m_pressed[b[5:0]]) want = 1'b0;
      end
      if ((m_neg & m_pressed) != 64'd0) want = 1'b0;
      if (cont) begin
        if (want && !m_cont) begin
          m_cont = 1'b1;
          r.cont_start = 1'b1;
        end else if (!want && m_cont) begin
          m_cont = 1'b0;
          r.cont_stop = 1'b1;
        end
      end
    end else begin
      if (act == ACT_PRESS) m_pressed[id] = 1'b1;
      else if (act == ACT_RELEASE) m_pressed[id] = 1'b0;
      if (step_hit(m_pos, act, id)) begin
        if ((m_neg & m_pressed) != 64'd0) begin
          r.seq_reset = (m_pos != 4'd0);
          m_pos = 4'd0;
        end else begin
          m_pos++;
          if (m_pos == live_steps()) begin
            r.fired = 1'b1;
            m_pos = 4'd0;
            for (k = 0; k < 64; k++) begin
              if (m_pressed[k] && step_hit(m_pos, ACT_HELD, 6'(k))) m_pos++;
            end
          end
        end
      end else if (act == ACT_RELEASE && m_pos != 4'd0) begin
        m_pos = 4'd0;
        r.seq_reset = 1'b1;
      end
    end
    r.position = m_pos;
    return r;
  endfunction

  function automatic script_row_t cw(logic [1:0] idx, logic [63:0] val);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic script_row_t ev(logic [1:0] act, logic [5:0] btn);
    script_row_t r;
    r = '0;
    r.act = act;
    r.btn = btn;
    return r;
  endfunction

  function automatic script_row_t evk(logic [1:0] act, logic [5:0] btn, det_result_t want);
    script_row_t r;
    r = ev(act, btn);
    r.known = 1'b1;
    r.want = want;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_TABLE: begin
        m_table = val;
        m_pos = 4'd0;
      end
      CFG_STEP_COUNT: begin
        m_count = val[3:0];
        m_pos = 4'd0;
      end
      CFG_NEGATED_MASK: m_neg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(logic [1:0] act, logic [5:0] id, bit known, det_result_t want);
    det_result_t r;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.button <= id;
    do @(posedge clk); while (!in_ch.ready);
    r = detector_next(act, id);
    if (known) r = want;
    pending_results = {pending_results, r};
  endtask

  task automatic set_pattern(int sel);
    logic [63:0] tab;
    logic [63:0] neg;
    logic [3:0]  cnt;
    logic [1:0]  kind;
    int k;
    int pick;
    pool[0] = 6'd0;
    pool[1] = 6'd63;
    for (k = 2; k < 6; k++) pool[k] = 6'($urandom_range(0, 63));
    tab = '0;
    for (k = 0; k < 8; k++) begin
      if (sel == 3) kind = ACT_HELD;
      else if ($urandom_range(0, 15) == 0) kind = KIND_VOID;
      else kind = 2'($urandom_range(0, 2));
      tab[k*8 +: 8] = {kind, pool[$urandom_range(0, 5)]};
    end
    case (sel)
      0: begin
        cnt = 4'd8;
        neg = '0;
      end
      1: begin
        cnt = 4'd15;
        neg = 64'd1 << pool[2];
      end
      2: begin
        tab = '0;
        cnt = 4'd0;
        neg = '0;
      end
      3: begin
        cnt = 4'($urandom_range(1, 4));
        neg = 64'd1 << pool[5];
      end
      4: begin
        tab = '0;
        cnt = 4'd8;
        neg = '0;
      end
      5: begin
        tab = {$urandom, $urandom};
        cnt = 4'($urandom_range(9, 14));
        neg = {$urandom, $urandom};
      end
      default: begin
        cnt = 4'($urandom_range(1, 8));
        pick = $urandom_range(0, 9);
        if (pick < 5) neg = '0;
        else if (pick < 8) neg = 64'd1 << pool[$urandom_range(0, 5)];
        else if (pick < 9) neg = {$urandom, $urandom};
        else neg = '1;
      end
    endcase
    write_reg(CFG_STEP_TABLE, tab);
    write_reg(CFG_STEP_COUNT, {60'd0, cnt});
    write_reg(CFG_NEGATED_MASK, neg);
  endtask

  task automatic next_word(output logic [1:0] act, output logic [5:0] id);
    logic [7:0] b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60 && m_pos < live_steps()) begin
      b = step_at(m_pos);
      act = (b[7:6] == KIND_VOID) ? 2'($urandom_range(0, 2)) : b[7:6];
      id = b[5:0];
    end else if (pick < 75) begin
      act = ACT_TICK;
      id = 6'($urandom);
    end else if (pick < 90) begin
      act = 2'($urandom_range(0, 2));
      id = pool[$urandom_range(0, 5)];
    end else begin
      act = 2'($urandom_range(0, 3));
      id = 6'($urandom_range(0, 63));
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    det_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, position", int'(out_ch.position_after), 0);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.fired !== e.fired)
          report_mismatch("fired", int'(out_ch.fired), int'(e.fired));
        if (out_ch.continuous_start !== e.cont_start)
          report_mismatch("continuous_start", int'(out_ch.continuous_start),
                          int'(e.cont_start));
        if (out_ch.continuous_stop !== e.cont_stop)
          report_mismatch("continuous_stop", int'(out_ch.continuous_stop),
                          int'(e.cont_stop));
        if (out_ch.position_after !== e.position)
          report_mismatch("position_after", int'(out_ch.position_after), int'(e.position));
        if (out_ch.sequence_reset !== e.seq_reset)
          report_mismatch("sequence_reset", int'(out_ch.sequence_reset), int'(e.seq_reset));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] act;
    logic [5:0] id;
    int ph;
    int j;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PRESS;
    in_ch.button = '0;
    m_table = '0;
    m_neg = '0;
    m_pressed = '0;
    m_count = '0;
    m_pos = '0;
    m_cont = 1'b0;
    errors = 0;
    gap_pct = 20;
    stall_pct = 20;
    hold_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    script = {
      evk(ACT_PRESS, 6'd0, '0),
      evk(ACT_HELD, 6'd63, '0),
      evk(ACT_RELEASE, 6'd63, '0),
      evk(ACT_TICK, 6'd0, '0),
      evk(ACT_RELEASE, 6'd0, '0),
      cw(CFG_STEP_TABLE, 64'h0000_0000_0085_3F05),
      cw(CFG_STEP_COUNT, 64'd3),
      ev(ACT_PRESS, 6'd5),
      ev(ACT_PRESS, 6'd63),
      ev(ACT_RELEASE, 6'd5),
      ev(ACT_PRESS, 6'd5),
      ev(ACT_RELEASE, 6'd9),
      cw(CFG_NEGATED_MASK, 64'h200),
      ev(ACT_PRESS, 6'd5),
      ev(ACT_PRESS, 6'd9),
      ev(ACT_PRESS, 6'd63),
      cw(CFG_STEP_TABLE, 64'h4241),
      cw(CFG_STEP_COUNT, 64'd2),
      cw(CFG_NEGATED_MASK, 64'd0),
      ev(ACT_PRESS, 6'd1),
      ev(ACT_PRESS, 6'd2),
      ev(ACT_TICK, 6'd0),
      ev(ACT_HELD, 6'd1),
      ev(ACT_HELD, 6'd2),
      ev(ACT_HELD, 6'd1),
      ev(ACT_RELEASE, 6'd2),
      ev(ACT_TICK, 6'd0),
      cw(CFG_STEP_TABLE, '1),
      cw(CFG_STEP_COUNT, 64'd15),
      cw(CFG_NEGATED_MASK, '1),
      evk(ACT_PRESS, 6'd63, '0),
      evk(ACT_TICK, 6'd63, '0),
      evk(ACT_RELEASE, 6'd63, '0)
    };

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_results();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_word(script[i].act, script[i].btn, script[i].known, script[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == PHASES - 1) begin
        calm = 1'b1;
      end else if (ph == 7) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      end
      set_pattern(ph);
      if (ph == 5) hold_left = HOLD_CYCLES;
      for (j = 0; j < PHASE_WORDS; j++) begin
        if (ph == 6 && j == PHASE_WORDS / 2) drain_results();
        next_word(act, id);
        send_word(act, id, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
